@@ sv/ggep_extension_block_parser_macros.svh @@
// assertion macros for the extension block parser checker
// used by ggep_checker; expects clk and rst in scope
`ifndef GGEP_EXTENSION_BLOCK_PARSER_MACROS_SVH
`define GGEP_EXTENSION_BLOCK_PARSER_MACROS_SVH

// consequent must hold in the same cycle
`define GGEP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GGEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ggep_pkg.sv @@
// shared types and codes for the extension block parser
// no dependencies
package ggep_pkg;

  localparam int BYTE_W           = 8;
  localparam int VALUE_W          = 18;
  localparam int ERR_W            = 4;
  localparam int NRES             = 3;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 8;
  localparam int MAX_LEN_BYTES_DEF = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COBS  = 1'b1;

  localparam logic [1:0] KIND_ID  = 2'd0;
  localparam logic [1:0] KIND_HDR = 2'd1;
  localparam logic [1:0] KIND_PAY = 2'd2;
  localparam logic [1:0] KIND_ERR = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NO_MAGIC    = 4'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_FLAGS   = 4'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO_ID     = 4'd2;
  localparam logic [ERR_W-1:0] ERR_ZERO_LEN    = 4'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_LEN     = 4'd4;
  localparam logic [ERR_W-1:0] ERR_MANY_LEN    = 4'd5;
  localparam logic [ERR_W-1:0] ERR_SHORT       = 4'd6;
  localparam logic [ERR_W-1:0] ERR_COBS_ZERO   = 4'd7;
  localparam logic [ERR_W-1:0] ERR_COBS_OVERRUN = 4'd8;

  localparam logic [7:0] MAGIC_RESET = 8'hC3;
  localparam logic [7:0] COBS_FULL   = 8'hFF;

  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_FLAGS = 6'b000010,
    PH_ID    = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_PAY   = 6'b010000,
    PH_WAIT  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [VALUE_W-1:0] value;
    logic [1:0]         item_flags;
    logic [ERR_W-1:0]   error_code;
    logic               item_done;
    logic               block_done;
    logic               last_of_run;
  } result_t;

  // results caused by one input item, in order
  typedef struct packed {
    logic [1:0]           cnt;
    result_t [NRES-1:0]   res;
  } bundle_t;

endpackage

@@ sv/ggep_channels.sv @@
// valid/ready channel interfaces for packet bytes in and parse results out
// depends on ggep_pkg
interface ggep_in_if;
  import ggep_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              packet_end;
  modport source (output valid, in_byte, packet_end, input ready);
  modport sink   (input valid, in_byte, packet_end, output ready);
endinterface

interface ggep_out_if;
  import ggep_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [VALUE_W-1:0] value;
  logic [1:0]         item_flags;
  logic [ERR_W-1:0]   error_code;
  logic               item_done;
  logic               block_done;
  logic               last_of_run;
  modport source (output valid, kind, value, item_flags, error_code, item_done,
                  block_done, last_of_run, input ready);
  modport sink   (input valid, kind, value, item_flags, error_code, item_done,
                  block_done, last_of_run, output ready);
endinterface

@@ sv/ggep_core.sv @@
// input register, parser state and the per-byte step logic
// depends on ggep_pkg and ggep_in_if; feeds a result bundle to ggep_emit
module ggep_core #(
  parameter int MAX_LEN_BYTES = ggep_pkg::MAX_LEN_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [ggep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ggep_pkg::CFG_DATA_W-1:0]    cfg_data,
  ggep_in_if.sink                            in_ch,
  input  logic                               can_load,
  output ggep_pkg::bundle_t                  bundle,
  output logic                               bundle_load
);
  import ggep_pkg::*;

  localparam int LBW = $clog2(MAX_LEN_BYTES + 1);

  logic [7:0]         magic_value;
  logic               cobs_enable;

  logic               in_valid;
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_end;

  phase_t             phase, phase_next;
  logic [2:0]         cur_flags, cur_flags_next;
  logic [3:0]         id_left, id_left_next;
  logic [VALUE_W-1:0] len_accum, len_accum_next;
  logic [LBW-1:0]     len_seen, len_seen_next;
  logic [VALUE_W-1:0] payload_left, payload_left_next;
  logic [7:0]         run_left, run_left_next;
  logic               run_full, run_full_next;

  logic               fire;

  function automatic result_t mk(input logic [1:0] k, input logic [VALUE_W-1:0] v,
                                 input logic [1:0] f);
    result_t r;
    r            = '0;
    r.kind       = k;
    r.value      = v;
    r.item_flags = f;
    return r;
  endfunction

  assign fire        = in_valid && can_load;
  assign bundle_load = fire;
  assign in_ch.ready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value <= MAGIC_RESET;
      cobs_enable <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAGIC: magic_value <= cfg_data[7:0];
        REG_COBS:  cobs_enable <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cur_byte <= in_ch.in_byte;
      cur_end  <= in_ch.packet_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      cur_flags    <= '0;
      id_left      <= '0;
      len_accum    <= '0;
      len_seen     <= '0;
      payload_left <= '0;
      run_left     <= '0;
      run_full     <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      cur_flags    <= cur_flags_next;
      id_left      <= id_left_next;
      len_accum    <= len_accum_next;
      len_seen     <= len_seen_next;
      payload_left <= payload_left_next;
      run_left     <= run_left_next;
      run_full     <= run_full_next;
    end
  end

  result_t            main0, main1, err_res;
  logic [1:0]         mcnt;
  logic               errv, short_err, finish;
  logic [ERR_W-1:0]   ecode;
  logic [VALUE_W-1:0] acc_new, rest;
  logic [7:0]         glen, run_dec;
  logic [3:0]         id_dec;
  logic [LBW:0]       seen_inc;

  always_comb begin
    phase_next        = phase;
    cur_flags_next    = cur_flags;
    id_left_next      = id_left;
    len_accum_next    = len_accum;
    len_seen_next     = len_seen;
    payload_left_next = payload_left;
    run_left_next     = run_left;
    run_full_next     = run_full;
    main0             = '0;
    main1             = '0;
    mcnt              = 2'd0;
    errv              = 1'b0;
    ecode             = ERR_NO_MAGIC;
    finish            = 1'b0;
    acc_new           = {len_accum[VALUE_W-7:0], cur_byte[5:0]};
    rest              = (payload_left == '0) ? '0 : payload_left - VALUE_W'(1);
    glen              = cur_byte - 8'd1;
    run_dec           = run_left - 8'd1;
    id_dec            = id_left - 4'd1;
    seen_inc          = {1'b0, len_seen} + (LBW+1)'(1);

    case (phase)
      PH_HUNT: begin
        if (cur_end) begin
          errv  = 1'b1;
          ecode = ERR_NO_MAGIC;
        end else if (cur_byte == magic_value) begin
          phase_next = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        if (cur_byte[3:0] == 4'd0 || cur_byte[4]) begin
          errv  = 1'b1;
          ecode = ERR_BAD_FLAGS;
        end else begin
          cur_flags_next = {cur_byte[7], cur_byte[5], cur_byte[6]};
          id_left_next   = cur_byte[3:0];
          len_accum_next = '0;
          len_seen_next  = '0;
          run_left_next  = '0;
          run_full_next  = 1'b0;
          phase_next     = PH_ID;
        end
      end
      PH_ID: begin
        if (cur_byte == 8'd0) begin
          errv  = 1'b1;
          ecode = ERR_ZERO_ID;
        end else begin
          main0        = mk(KIND_ID, VALUE_W'(cur_byte), cur_flags[1:0]);
          mcnt         = 2'd1;
          id_left_next = id_dec;
          if (id_dec == 4'd0) begin
            phase_next = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        if (cur_byte == 8'd0) begin
          errv  = 1'b1;
          ecode = ERR_ZERO_LEN;
        end else begin
          len_accum_next = acc_new;
          // bit 6 marks the last length byte, bit 7 says more follow
          if (cur_byte[6]) begin
            if (cur_byte[7]) begin
              errv  = 1'b1;
              ecode = ERR_BAD_LEN;
            end else begin
              main0             = mk(KIND_HDR, acc_new, cur_flags[1:0]);
              mcnt              = 2'd1;
              payload_left_next = acc_new;
              run_left_next     = '0;
              run_full_next     = 1'b0;
              if (acc_new == '0) begin
                finish = 1'b1;
              end else begin
                phase_next = PH_PAY;
              end
            end
          end else if (!cur_byte[7]) begin
            errv  = 1'b1;
            ecode = ERR_BAD_LEN;
          end else if (seen_inc >= (LBW+1)'(MAX_LEN_BYTES)) begin
            errv  = 1'b1;
            ecode = ERR_MANY_LEN;
          end else begin
            len_seen_next = seen_inc[LBW-1:0];
          end
        end
      end
      PH_PAY: begin
        if (cur_flags[0] && cobs_enable) begin
          if (run_left == 8'd0) begin
            // code byte of a new group
            if (cur_byte == 8'd0) begin
              errv  = 1'b1;
              ecode = ERR_COBS_ZERO;
            end else if (VALUE_W'(glen) > rest) begin
              errv  = 1'b1;
              ecode = ERR_COBS_OVERRUN;
            end else begin
              run_left_next = glen;
              run_full_next = (cur_byte == COBS_FULL);
              if (glen == 8'd0) begin
                main0 = mk(KIND_PAY, '0, cur_flags[1:0]);
                mcnt  = 2'd1;
              end
            end
          end else begin
            main0         = mk(KIND_PAY, VALUE_W'(cur_byte), cur_flags[1:0]);
            mcnt          = 2'd1;
            run_left_next = run_dec;
            if (run_dec == 8'd0 && !run_full) begin
              main1 = mk(KIND_PAY, '0, cur_flags[1:0]);
              mcnt  = 2'd2;
            end
          end
        end else begin
          main0 = mk(KIND_PAY, VALUE_W'(cur_byte), cur_flags[1:0]);
          mcnt  = 2'd1;
        end
        if (!errv) begin
          payload_left_next = rest;
          if (rest == '0) begin
            finish = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (finish && mcnt != 2'd0) begin
      if (cur_flags[2]) begin
        phase_next = PH_WAIT;
      end else begin
        phase_next = PH_FLAGS;
      end
      if (mcnt == 2'd2) begin
        main1.item_done  = 1'b1;
        main1.block_done = cur_flags[2];
      end else begin
        main0.item_done  = 1'b1;
        main0.block_done = cur_flags[2];
      end
    end

    // packet ran out inside a block that is still open
    short_err = !errv && cur_end && phase_next != PH_WAIT && phase_next != PH_HUNT;
    if (errv) begin
      phase_next = PH_WAIT;
    end
    if (cur_end) begin
      phase_next = PH_HUNT;
    end

    err_res            = '0;
    err_res.kind       = KIND_ERR;
    err_res.error_code = errv ? ecode : ERR_SHORT;

    bundle        = '0;
    bundle.res[0] = main0;
    bundle.res[1] = main1;
    bundle.cnt    = mcnt;
    if (errv || short_err) begin
      bundle.res[mcnt] = err_res;
      bundle.cnt       = mcnt + 2'd1;
    end
    for (int i = 0; i < NRES; i++) begin
      bundle.res[i].last_of_run = (bundle.cnt == 2'(i + 1));
    end
  end

endmodule

@@ sv/ggep_emit.sv @@
// result register that hands out one result per cycle from a loaded bundle while the output is ready
// depends on ggep_pkg and ggep_out_if
module ggep_emit (
  input  logic              clk,
  input  logic              rst,
  input  ggep_pkg::bundle_t bundle,
  input  logic              bundle_load,
  output logic              can_load,
  ggep_out_if.source        out_ch
);
  import ggep_pkg::*;

  result_t [NRES-1:0] slots;
  logic [1:0]         head;
  logic [1:0]         left;
  logic               take;
  result_t            cur;

  assign take     = out_ch.valid && out_ch.ready;
  // free now, or the last waiting result leaves this cycle
  assign can_load = (left == 2'd0) || (left == 2'd1 && out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 2'd0;
      head <= 2'd0;
    end else if (bundle_load) begin
      left <= bundle.cnt;
      head <= 2'd0;
    end else if (take) begin
      left <= left - 2'd1;
      head <= head + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_load) begin
      slots <= bundle.res;
    end
  end

  assign cur               = slots[head];
  assign out_ch.valid       = (left != 2'd0);
  assign out_ch.kind        = cur.kind;
  assign out_ch.value       = cur.value;
  assign out_ch.item_flags  = cur.item_flags;
  assign out_ch.error_code  = cur.error_code;
  assign out_ch.item_done   = cur.item_done;
  assign out_ch.block_done  = cur.block_done;
  assign out_ch.last_of_run = cur.last_of_run;

endmodule

@@ sv/ggep_extension_block_parser.sv @@
// Extension block parser: takes one packet byte per item, finds the magic byte, then
// walks flags, id bytes, 6-bit length bytes and payload of each extension, undoing
// COBS inline when enabled. A byte is registered on entry, the parser state steps
// on it and up to three results land in the result register, which hands them out
// one per cycle while the output is ready. A byte that causes at most one result
// lets the next byte in as its result leaves, so the sustained rate is one byte
// per cycle while the output is ready; a byte that causes more results stalls the
// input until its last result is leaving, set by the one-result output port. The
// first result is presented from the result register once its byte has passed the
// input register. Depends on ggep_pkg, ggep_channels, ggep_core and ggep_emit.
module ggep_extension_block_parser #(
  parameter int MAX_LEN_BYTES = ggep_pkg::MAX_LEN_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ggep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ggep_pkg::CFG_DATA_W-1:0] cfg_data,
  ggep_in_if.sink                         in_ch,
  ggep_out_if.source                      out_ch
);
  import ggep_pkg::*;

  bundle_t bundle;
  logic    bundle_load;
  logic    can_load;

  ggep_core #(
    .MAX_LEN_BYTES(MAX_LEN_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .can_load   (can_load),
    .bundle     (bundle),
    .bundle_load(bundle_load)
  );

  ggep_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .bundle     (bundle),
    .bundle_load(bundle_load),
    .can_load   (can_load),
    .out_ch     (out_ch)
  );

endmodule

@@ sv/ggep_checker.sv @@
// port-level checks on the parser's result channel, bound to the top level
// depends on ggep_pkg and ggep_extension_block_parser_macros.svh
`include "ggep_extension_block_parser_macros.svh"

module ggep_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         valid,
  input logic                         ready,
  input logic [1:0]                   kind,
  input logic [ggep_pkg::VALUE_W-1:0] value,
  input logic [1:0]                   item_flags,
  input logic [ggep_pkg::ERR_W-1:0]   error_code,
  input logic                         item_done,
  input logic                         block_done,
  input logic                         last_of_run
);
  import ggep_pkg::*;

  // an error closes the run and carries nothing else
  `GGEP_ASSERT_NOW(a_err_shape, valid && kind == KIND_ERR,
    last_of_run && value == '0 && item_flags == 2'd0 && item_done == 1'b0 &&
    block_done == 1'b0 && error_code <= ERR_COBS_OVERRUN, "error item malformed")

  `GGEP_ASSERT_NOW(a_code_only_err, valid && kind != KIND_ERR, error_code == '0,
    "error code on non-error item")

  // block completion is also item completion and ends the run
  `GGEP_ASSERT_NOW(a_block_done, valid && block_done,
    item_done && last_of_run && kind != KIND_ERR && kind != KIND_ID, "block done misplaced")

  `GGEP_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable({kind, value, item_flags,
    error_code, item_done, block_done, last_of_run}), "stalled result changed")

endmodule

bind ggep_extension_block_parser ggep_checker u_ggep_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (out_ch.valid),
  .ready      (out_ch.ready),
  .kind       (out_ch.kind),
  .value      (out_ch.value),
  .item_flags (out_ch.item_flags),
  .error_code (out_ch.error_code),
  .item_done  (out_ch.item_done),
  .block_done (out_ch.block_done),
  .last_of_run(out_ch.last_of_run)
);
